### rtl/sfh_pkg.sv
// ----------------------------------------------------------------------------
// sfh_pkg
// Shared types and hash arithmetic for the byte stream hash core.
// ----------------------------------------------------------------------------
package sfh_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 31;
  localparam int unsigned HashW   = 32;
  localparam int unsigned HeldW   = 24;
  localparam int unsigned CountW  = 2;
  localparam int unsigned InDataW = 40;

  // Group position codes
  localparam logic [CountW-1:0] POS_NONE  = 2'd0;
  localparam logic [CountW-1:0] POS_ONE   = 2'd1;
  localparam logic [CountW-1:0] POS_TWO   = 2'd2;
  localparam logic [CountW-1:0] POS_THREE = 2'd3;

  // Finish job handed from the accumulator to the finishing pipeline
  typedef struct packed {
    logic [HashW-1:0]  hash;
    logic [HeldW-1:0]  held;
    logic [CountW-1:0] count;
    logic              order;
    logic              empty;
  } sfh_job_t;

  // Build a 16-bit half from two stream bytes in the selected byte order
  function automatic logic [15:0] form_half(input logic order, input logic [7:0] first,
                                            input logic [7:0] second);
    return order ? {first, second} : {second, first};
  endfunction

  function automatic logic [31:0] sign_byte(input logic [7:0] b);
    return {{24{b[7]}}, b};
  endfunction

  // One mixing round over a full group of four bytes
  function automatic logic [31:0] mix_round(input logic [31:0] h, input logic [15:0] lo,
                                            input logic [15:0] hi);
    logic [31:0] x;
    logic [31:0] t;
    x = h + {16'd0, lo};
    t = ({16'd0, hi} << 11) ^ x;
    x = (x << 16) ^ t;
    x = x + (x >> 11);
    return x;
  endfunction

  // Tail rule for a leftover of one to three bytes
  function automatic logic [31:0] tail_mix(input logic [31:0] h, input logic [1:0] count,
                                           input logic [23:0] held, input logic order);
    logic [31:0] x;
    x = h;
    case (count)
      POS_THREE: begin
        x = x + {16'd0, form_half(order, held[7:0], held[15:8])};
        x = x ^ (x << 16);
        x = x ^ (sign_byte(held[23:16]) << 18);
        x = x + (x >> 11);
      end
      POS_TWO: begin
        x = x + {16'd0, form_half(order, held[7:0], held[15:8])};
        x = x ^ (x << 11);
        x = x + (x >> 17);
      end
      POS_ONE: begin
        x = x + sign_byte(held[7:0]);
        x = x ^ (x << 10);
        x = x + (x >> 1);
      end
      default: x = h;
    endcase
    return x;
  endfunction

  // First half of the avalanche
  function automatic logic [31:0] aval_a(input logic [31:0] h);
    logic [31:0] x;
    x = h ^ (h << 3);
    x = x + (x >> 5);
    x = x ^ (x << 4);
    return x;
  endfunction

  // Second half of the avalanche
  function automatic logic [31:0] aval_b(input logic [31:0] h);
    logic [31:0] x;
    x = h + (h >> 17);
    x = x ^ (x << 25);
    x = x + (x >> 6);
    return x;
  endfunction

endpackage

### rtl/sfh_accum.sv
// ----------------------------------------------------------------------------
// sfh_accum
// Input register, running hash state and group rounds; issues finish jobs.
// ----------------------------------------------------------------------------
module sfh_accum (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      order_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [sfh_pkg::ByteW-1:0] byte_i,
  input  logic [sfh_pkg::LenW-1:0]  length_i,
  input  logic                      last_i,
  output logic                      job_valid_o,
  input  logic                      job_ready_i,
  output sfh_pkg::sfh_job_t         job_o
);
  import sfh_pkg::*;

  logic              in_v_q;
  logic [ByteW-1:0]  in_byte_q;
  logic [LenW-1:0]   in_len_q;
  logic              in_last_q;

  logic              open_q;
  logic [HashW-1:0]  h_q;
  logic [HeldW-1:0]  pend_q;
  logic [CountW-1:0] pos_q;

  logic              job_v_q;
  sfh_job_t          job_q;
  sfh_job_t          job_d;

  logic              empty;
  logic              emits;
  logic              job_rdy;
  logic              take;
  logic [HashW-1:0]  h_w;
  logic [HeldW-1:0]  pend_w;
  logic [CountW-1:0] pos_w;
  logic [HashW-1:0]  h_d;
  logic [HeldW-1:0]  pend_d;
  logic [CountW-1:0] pos_d;

  // Consume the held item when its result, if any, has room downstream
  assign empty      = !open_q && (in_len_q == '0);
  assign emits      = empty || in_last_q;
  assign job_rdy    = !job_v_q || job_ready_i;
  assign take       = in_v_q && (!emits || job_rdy);
  assign in_ready_o = !in_v_q || take;

  // Seed on the first byte, then run a round or collect the byte
  always_comb begin
    h_w    = open_q ? h_q : {1'b0, in_len_q};
    pend_w = open_q ? pend_q : '0;
    pos_w  = open_q ? pos_q : POS_NONE;
    h_d    = h_w;
    pend_d = pend_w;
    pos_d  = pos_w + 2'd1;
    case (pos_w)
      POS_NONE:  pend_d = {pend_w[23:8], in_byte_q};
      POS_ONE:   pend_d = {pend_w[23:16], in_byte_q, pend_w[7:0]};
      POS_TWO:   pend_d = {in_byte_q, pend_w[15:0]};
      POS_THREE: begin
        h_d    = mix_round(h_w, form_half(order_i, pend_w[7:0], pend_w[15:8]),
                           form_half(order_i, pend_w[23:16], in_byte_q));
        pend_d = '0;
        pos_d  = POS_NONE;
      end
      default: pend_d = pend_w;
    endcase
    job_d.hash  = h_d;
    job_d.held  = pend_d;
    job_d.count = pos_d;
    job_d.order = order_i;
    job_d.empty = empty;
  end

  // Hold the incoming item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= byte_i;
      in_len_q  <= length_i;
      in_last_q <= last_i;
    end
  end

  // Advance the running state; clear it after the final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      h_q    <= '0;
      pend_q <= '0;
      pos_q  <= POS_NONE;
    end else if (take && !empty) begin
      if (in_last_q) begin
        open_q <= 1'b0;
        h_q    <= '0;
        pend_q <= '0;
        pos_q  <= POS_NONE;
      end else begin
        open_q <= 1'b1;
        h_q    <= h_d;
        pend_q <= pend_d;
        pos_q  <= pos_d;
      end
    end
  end

  // Job register toward the finishing pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_v_q <= 1'b0;
    end else if (job_rdy) begin
      job_v_q <= take && emits;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_rdy && take && emits) begin
      job_q <= job_d;
    end
  end

  assign job_valid_o = job_v_q;
  assign job_o       = job_q;

endmodule

### rtl/sfh_finish.sv
// ----------------------------------------------------------------------------
// sfh_finish
// Three-stage finishing pipeline: tail rule, avalanche halves, result register.
// ----------------------------------------------------------------------------
module sfh_finish (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      job_valid_i,
  output logic                      job_ready_o,
  input  sfh_pkg::sfh_job_t         job_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [sfh_pkg::HashW-1:0] hash_o
);
  import sfh_pkg::*;

  logic             t_v_q;
  logic [HashW-1:0] t_h_q;
  logic             t_z_q;
  logic             a_v_q;
  logic [HashW-1:0] a_h_q;
  logic             a_z_q;
  logic             o_v_q;
  logic [HashW-1:0] o_h_q;

  logic             t_rdy;
  logic             a_rdy;
  logic             o_rdy;

  // Each stage moves when it is empty or its successor moves
  assign o_rdy       = !o_v_q || out_ready_i;
  assign a_rdy       = !a_v_q || o_rdy;
  assign t_rdy       = !t_v_q || a_rdy;
  assign job_ready_o = t_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_v_q <= 1'b0;
      a_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (t_rdy) t_v_q <= job_valid_i;
      if (a_rdy) a_v_q <= t_v_q;
      if (o_rdy) o_v_q <= a_v_q;
    end
  end

  // Tail rule, first avalanche half, then second half into the result
  always_ff @(posedge clk_i) begin
    if (t_rdy && job_valid_i) begin
      t_h_q <= tail_mix(job_i.hash, job_i.count, job_i.held, job_i.order);
      t_z_q <= job_i.empty;
    end
    if (a_rdy && t_v_q) begin
      a_h_q <= aval_a(t_h_q);
      a_z_q <= t_z_q;
    end
    if (o_rdy && a_v_q) begin
      o_h_q <= a_z_q ? '0 : aval_b(a_h_q);
    end
  end

  assign out_valid_o = o_v_q;
  assign hash_o      = o_h_q;

endmodule

### rtl/superfast_byte_stream_hash_core.sv
// Result path: input register, job register, then tail, avalanche and result stages.
// One byte per cycle unless the job path stalls; the group round is combinational.
// Finishing runs in a 3-stage pipeline, so back-to-back short messages stream freely.
// Reset: rst_ni clears the running hash, byte order register and all valid flags.
// ----------------------------------------------------------------------------
// superfast_byte_stream_hash_core
// Streaming 32-bit byte hash: accumulator with group rounds, then tail and avalanche.
// ----------------------------------------------------------------------------
module superfast_byte_stream_hash_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [7:0] data_byte, [38:8] message_length, [39] zero
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [31:0] hash_value
);
  import sfh_pkg::*;

  logic     order_q;
  logic     job_valid;
  logic     job_ready;
  sfh_job_t job;

  // Byte order register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= 1'b0;
    end else if (cfg_we_i) begin
      order_q <= cfg_wdata_i;
    end
  end

  sfh_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .order_i     (order_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .byte_i      (s_axis_tdata[ByteW-1:0]),
    .length_i    (s_axis_tdata[ByteW+LenW-1:ByteW]),
    .last_i      (s_axis_tlast),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  sfh_finish u_finish (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .hash_o      (m_axis_tdata)
  );

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the byte stream hash core against an in-bench hash predictor.
// Byte items go in through a bursty stream sender. Hash items are checked in
// order against predicted values while the receiver is always ready or stalls at random or on a pattern.
// Covered: empty messages, every tail size, full groups, long messages, stale
// or wrong message lengths, and both byte orders.
// ----------------------------------------------------------------------------
module tb_top;
  import sfh_pkg::*;

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_e;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_wdata_i;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata;   // [7:0] data_byte, [38:8] message_length, [39] zero
  logic               s_axis_tlast;   // last_byte
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [HashW-1:0]   m_axis_tdata;   // [31:0] hash_value

  // Predictor state
  logic [HashW-1:0]  run_hash;
  logic [HeldW-1:0]  held_bytes;
  logic [CountW-1:0] held_count;
  logic              msg_open;
  logic              half_order;

  logic [HashW-1:0] expected_hashes[$];

  int unsigned mismatch_count;
  int unsigned bytes_sent;
  int unsigned msgs_sent;
  int unsigned empties_sent;
  int unsigned hashes_checked;
  int unsigned burst_left;
  bit          tx_steady;
  rx_mode_e    rx_mode = RX_ALWAYS;
  logic [15:0] rx_pattern = 16'hB5A3;

  superfast_byte_stream_hash_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Hash predictor
  // ---------------------------------------------------------------------------

  // Join two stream bytes into a 16-bit half in the selected order
  function automatic logic [15:0] pair_half(input logic [7:0] first_b,
                                            input logic [7:0] second_b);
    return half_order ? {first_b, second_b} : {second_b, first_b};
  endfunction

  function automatic logic [31:0] sext8(input logic [7:0] b);
    return {{24{b[7]}}, b};
  endfunction

  function automatic logic [31:0] group_round(input logic [31:0] h, input logic [15:0] lo,
                                              input logic [15:0] hi);
    logic [31:0] x;
    logic [31:0] t;
    x = h + {16'd0, lo};
    t = ({16'd0, hi} << 11) ^ x;
    x = (x << 16) ^ t;
    x = x + (x >> 11);
    return x;
  endfunction

  // Tail rule for the leftover bytes, then the avalanche
  function automatic logic [31:0] finish_hash(input logic [31:0] h, input logic [1:0] cnt,
                                              input logic [23:0] held);
    logic [31:0] x;
    x = h;
    case (cnt)
      POS_THREE: begin
        x = x + {16'd0, pair_half(held[7:0], held[15:8])};
        x = x ^ (x << 16);
        x = x ^ (sext8(held[23:16]) << 18);
        x = x + (x >> 11);
      end
      POS_TWO: begin
        x = x + {16'd0, pair_half(held[7:0], held[15:8])};
        x = x ^ (x << 11);
        x = x + (x >> 17);
      end
      POS_ONE: begin
        x = x + sext8(held[7:0]);
        x = x ^ (x << 10);
        x = x + (x >> 1);
      end
      default: ;
    endcase
    x = x ^ (x << 3);
    x = x + (x >> 5);
    x = x ^ (x << 4);
    x = x + (x >> 17);
    x = x ^ (x << 25);
    x = x + (x >> 6);
    return x;
  endfunction

  // Advance the predictor by one byte item; returns 1 when a hash comes out
  function automatic bit hash_step(input logic [7:0] data_b, input logic [LenW-1:0] len,
                                   input logic is_last, output logic [31:0] hash);
    hash = '0;
    if (!msg_open) begin
      if (len == '0) begin
        return 1'b1;
      end
      run_hash   = {1'b0, len};
      held_bytes = '0;
      held_count = POS_NONE;
      msg_open   = 1'b1;
    end
    if (held_count == POS_THREE) begin
      run_hash = group_round(run_hash, pair_half(held_bytes[7:0], held_bytes[15:8]),
                             pair_half(held_bytes[23:16], data_b));
      held_bytes = '0;
      held_count = POS_NONE;
    end else begin
      case (held_count)
        POS_NONE: held_bytes[7:0]   = data_b;
        POS_ONE:  held_bytes[15:8]  = data_b;
        default:  held_bytes[23:16] = data_b;
      endcase
      held_count = held_count + 1'b1;
    end
    if (is_last) begin
      hash       = finish_hash(run_hash, held_count, held_bytes);
      run_hash   = '0;
      held_bytes = '0;
      held_count = POS_NONE;
      msg_open   = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender, receiver and checker
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    if (mismatch_count < 40) begin
      $display("%0t: MISMATCH %s: expected %08h, got %08h", $realtime, what, want, got);
    end
    mismatch_count++;
  endtask

  // Send one byte item; possibly idle first when the current burst is used up
  task automatic push_byte(input logic [7:0] data_b, input logic [LenW-1:0] len,
                           input logic is_last);
    int unsigned gap;
    logic [31:0] hash;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (tx_steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, len, data_b};
    s_axis_tlast  <= is_last;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    if (hash_step(data_b, len, is_last, hash)) begin
      expected_hashes.push_back(hash);
    end
  endtask

  // Drop valid and let the core drain before touching the register
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_hashes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_order(input logic order);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= order;
    @(posedge clk_i);
    half_order = order;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Corner values of a byte turn up more often than plain random
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  // One message of random size; with a wrong seed the length fields are junk
  task automatic send_random_message(input bit wrong_seed);
    int unsigned n;
    logic [LenW-1:0] seed;
    logic [LenW-1:0] len;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
    if (!wrong_seed) begin
      seed = LenW'(n);
    end else if ($urandom_range(0, 3) == 0) begin
      seed = {LenW{1'b1}};
    end else begin
      seed = LenW'($urandom);
    end
    if (seed == '0) seed = LenW'(1);
    for (int unsigned i = 0; i < n; i++) begin
      len = (i == 0) ? seed : (wrong_seed ? LenW'($urandom) : seed);
      push_byte(pick_byte(), len, i == n - 1);
    end
    msgs_sent++;
  endtask

  task automatic send_empty();
    push_byte(8'($urandom), '0, 1'($urandom));
    empties_sent++;
  endtask

  // Receiver backpressure
  always @(negedge clk_i) begin
    case (rx_mode)
      RX_ALWAYS: m_axis_tready <= 1'b1;
      RX_RANDOM: m_axis_tready <= ($urandom_range(0, 3) != 0);
      default: begin
        m_axis_tready <= rx_pattern[0];
        rx_pattern    <= {rx_pattern[0], rx_pattern[15:1]};
      end
    endcase
  end

  // Compare each hash item with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_hashes.size() == 0) begin
        report_mismatch("hash_value with nothing pending", '0, m_axis_tdata);
      end else begin
        if (m_axis_tdata !== expected_hashes[0]) begin
          report_mismatch("hash_value", expected_hashes[0], m_axis_tdata);
        end
        void'(expected_hashes.pop_front());
        hashes_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty messages, every tail size, a full group, sign bytes and odd lengths
  task automatic test_directed_corners();
    push_byte(8'hA5, '0, 1'b1);
    push_byte(8'h00, '0, 1'b0);
    empties_sent += 2;
    push_byte(8'h80, 31'd1, 1'b1);
    push_byte(8'h7F, {LenW{1'b1}}, 1'b1);
    push_byte(8'hFF, 31'd2, 1'b0);
    push_byte(8'hFF, 31'd2, 1'b1);
    push_byte(8'h12, 31'd3, 1'b0);
    push_byte(8'h34, 31'd3, 1'b0);
    push_byte(8'h80, 31'd3, 1'b1);
    push_byte(8'h00, 31'd4, 1'b0);
    push_byte(8'hFF, 31'd4, 1'b0);
    push_byte(8'h00, 31'd4, 1'b0);
    push_byte(8'hFF, 31'd4, 1'b1);
    // Length on later bytes must not matter, zero included
    push_byte(8'h5A, 31'd5, 1'b0);
    push_byte(8'hC3, 31'd0, 1'b0);
    push_byte(8'h01, 31'h2AAA_AAAA, 1'b0);
    push_byte(8'hFE, 31'h5555_5555, 1'b0);
    push_byte(8'hFF, 31'd0, 1'b1);
    // Seed length disagrees with the byte count
    push_byte(8'h3C, 31'd100, 1'b0);
    push_byte(8'h81, 31'd100, 1'b1);
    msgs_sent += 7;
  endtask

  // Well-formed messages and empties under one byte order and one backpressure style
  task automatic test_byte_order(input logic order, input rx_mode_e mode,
                                 input int unsigned item_goal);
    int unsigned stop_at;
    wait_idle();
    rx_mode    = mode;
    rx_pattern = 16'($urandom) | 16'h1111;
    write_order(order);
    tx_steady  = ($urandom_range(0, 1) == 0);
    stop_at    = bytes_sent + item_goal;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) send_empty();
      else send_random_message(1'b0);
    end
  endtask

  // Junk seeds and changing length fields inside messages
  task automatic test_length_mismatch(input int unsigned item_goal);
    int unsigned stop_at;
    wait_idle();
    write_order(1'($urandom));
    rx_mode   = RX_RANDOM;
    tx_steady = 1'b0;
    stop_at   = bytes_sent + item_goal;
    while (bytes_sent < stop_at) begin
      send_random_message($urandom_range(0, 3) != 0);
    end
  endtask

  // Short messages and empties back to back to fill the finishing pipeline
  task automatic test_short_burst(input int unsigned item_goal);
    int unsigned stop_at;
    int unsigned n;
    wait_idle();
    rx_mode   = RX_ALWAYS;
    tx_steady = 1'b1;
    stop_at   = bytes_sent + item_goal;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 2) == 0) begin
        send_empty();
      end else begin
        n = $urandom_range(1, 3);
        for (int unsigned i = 0; i < n; i++) begin
          push_byte(pick_byte(), LenW'(n), i == n - 1);
        end
        msgs_sent++;
      end
    end
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b1;
    run_hash      = '0;
    held_bytes    = '0;
    held_count    = POS_NONE;
    msg_open      = 1'b0;
    half_order    = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_corners();
    test_byte_order(1'b1, RX_PATTERN, 330);
    test_byte_order(1'b0, RX_RANDOM, 330);
    test_byte_order(1'b1, RX_ALWAYS, 330);
    test_byte_order(1'b0, RX_PATTERN, 330);
    test_length_mismatch(200);
    test_short_burst(110);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_hashes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d byte items in %0d messages plus %0d empty items.",
             bytes_sent, msgs_sent, empties_sent);
    $display("Checked %0d hashes under both byte orders with bursty input and output stalls.",
             hashes_checked);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Timeout with %0d hashes still pending", expected_hashes.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
